### hdl/teq_pkg.sv
// Shared constants for the timed event release queue.
package teq_pkg;
  localparam int STAMP_BITS = 32;
  localparam int COUNT_BITS = 7;
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_PICK     = 1'b1;
endpackage

### hdl/teq_if.sv
// Handshake channel interfaces of the timed event release queue.
interface teq_in_if #(parameter int TAG_BITS = 32, parameter int TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [TAG_BITS-1:0]  event_tag;
  logic [TIME_BITS-1:0] due_time;
  logic                 prefetch_flag;
  logic [TIME_BITS-1:0] now_time;
  modport source(output valid, operation, event_tag, due_time, prefetch_flag, now_time,
                 input ready);
  modport sink(input valid, operation, event_tag, due_time, prefetch_flag, now_time,
               output ready);
endinterface

interface teq_out_if #(parameter int TAG_BITS = 32, parameter int TIME_BITS = 48);
  logic                            valid;
  logic                            ready;
  logic                            released;
  logic [TAG_BITS-1:0]             out_tag;
  logic [TIME_BITS-1:0]            out_due_time;
  logic                            out_prefetch;
  logic                            accepted;
  logic [teq_pkg::COUNT_BITS-1:0]  pending_count;
  modport source(output valid, released, out_tag, out_due_time, out_prefetch, accepted,
                 pending_count, input ready);
  modport sink(input valid, released, out_tag, out_due_time, out_prefetch, accepted,
               pending_count, output ready);
endinterface

interface teq_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### hdl/teq_slot_ram.sv
// Slot memory: one write port, one read port with registered read data.
module teq_slot_ram #(
  parameter int WIDTH = 114,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/timed_event_release_queue.sv
// Top level of the timed event release queue: scan sequencer around the slot memory.
//
// Channel | Direction | Carries
// in      | sink      | operation, event_tag, due_time, prefetch_flag, now_time
// out     | source    | released, out_tag, out_due_time, out_prefetch, accepted, pending_count
// cfg     | sink      | out_of_order_mode
//
// Every item but a schedule into a full queue scans the slot memory at one entry
// per cycle through its single read port; such a schedule goes straight to the
// finish state. The result is registered when the finish state ends, and only then
// is the next item taken, in the idle state.
// After reset a clearing pass marks every slot free; no item is taken meanwhile.
// A result waits in the output register; a finished item holds until that register
// is free, and the next item is taken while a result waits.
module timed_event_release_queue #(
  parameter int DEPTH     = 64,
  parameter int TAG_BITS  = 32,
  parameter int TIME_BITS = 48
) (
  input  logic clk,
  input  logic rst,
  teq_in_if.sink   in,
  teq_out_if.source out,
  teq_cfg_if.sink  cfg
);
  import teq_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EW  = 1 + STAMP_BITS + 1 + TIME_BITS + TAG_BITS;
  localparam int DUE_LO = TAG_BITS;
  localparam int PF_BIT = TAG_BITS + TIME_BITS;
  localparam int ST_LO  = PF_BIT + 1;
  localparam int VB     = EW - 1;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  logic   mode;
  logic [CW-1:0]         held;
  logic [STAMP_BITS-1:0] stamp;
  logic [AW:0]           cnt;
  logic                  rd_pend;
  logic [AW-1:0]         rd_idx;

  logic                 op;
  logic [TAG_BITS-1:0]  tag;
  logic [TIME_BITS-1:0] due;
  logic                 pf;
  logic [TIME_BITS-1:0] now;

  logic                  found;
  logic [AW-1:0]         best_idx;
  logic [TIME_BITS-1:0]  best_due;
  logic [TAG_BITS-1:0]   best_tag;
  logic                  best_pf;
  logic [STAMP_BITS-1:0] best_stamp;
  logic                  free_found;
  logic [AW-1:0]         free_idx;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  teq_slot_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(cnt[AW-1:0]), .rdata(rdata)
  );

  logic                  e_valid;
  logic [TIME_BITS-1:0]  e_due;
  logic [STAMP_BITS-1:0] e_stamp;
  logic [STAMP_BITS-1:0] age_e, age_b;
  logic                  better;
  logic                  full;
  logic                  out_free;
  logic                  do_release;
  logic [CW+COUNT_BITS-1:0] held_ext;

  assign e_valid = rdata[VB];
  assign e_due   = rdata[DUE_LO +: TIME_BITS];
  assign e_stamp = rdata[ST_LO +: STAMP_BITS];
  assign age_e   = stamp - e_stamp;
  assign age_b   = stamp - best_stamp;
  assign full    = (held == CW'(DEPTH));
  assign out_free = !out.valid || out.ready;
  assign do_release = (op == OP_PICK) && found && (best_due <= now);

  always_comb begin
    if (!found) begin
      better = 1'b1;
    end else if (mode) begin
      better = (e_due < best_due) || ((e_due == best_due) && (age_e > age_b));
    end else begin
      better = age_e > age_b;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt[AW-1:0];
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_FINISH && out_free) begin
      if (op == OP_SCHEDULE) begin
        we    = free_found && !full;
        waddr = free_idx;
        wdata = {1'b1, stamp, pf, due, tag};
      end else begin
        we    = do_release;
        waddr = best_idx;
      end
    end
  end

  assign in.ready  = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg.valid) begin
      mode <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      held      <= '0;
      stamp     <= '0;
      rd_pend   <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      // In the finish state a free output register is loaded below instead.
      if (out.valid && out.ready && state != S_FINISH) begin
        out.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt == (AW+1)'(DEPTH - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in.valid) begin
            op  <= in.operation;
            tag <= in.event_tag;
            due <= in.due_time;
            pf  <= in.prefetch_flag;
            now <= in.now_time;
            found      <= 1'b0;
            free_found <= 1'b0;
            cnt        <= '0;
            rd_pend    <= 1'b0;
            if (in.operation == OP_SCHEDULE && full) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Reads are issued while cnt runs; data of the entry before arrives now.
          if (cnt != (AW+1)'(DEPTH)) begin
            cnt     <= cnt + 1'b1;
            rd_idx  <= cnt[AW-1:0];
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            if (e_valid && better) begin
              found      <= 1'b1;
              best_idx   <= rd_idx;
              best_due   <= e_due;
              best_tag   <= rdata[TAG_BITS-1:0];
              best_pf    <= rdata[PF_BIT];
              best_stamp <= e_stamp;
            end
            if (!e_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
          if (!rd_pend && cnt == (AW+1)'(DEPTH)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out.valid        <= 1'b1;
            out.released     <= do_release;
            out.out_tag      <= do_release ? best_tag : '0;
            out.out_due_time <= do_release ? best_due : '0;
            out.out_prefetch <= do_release && best_pf;
            out.accepted     <= (op == OP_SCHEDULE) && !full && free_found;
            out.pending_count <= held_ext[COUNT_BITS-1:0];
            if (op == OP_SCHEDULE && !full && free_found) begin
              held  <= held + 1'b1;
              stamp <= stamp + 1'b1;
            end else if (do_release) begin
              held <= held - 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Count reported with the item's effect applied, masked to the field width.
  always_comb begin
    held_ext = {{COUNT_BITS{1'b0}}, held};
    if (op == OP_SCHEDULE && !full && free_found) begin
      held_ext = held_ext + 1'b1;
    end else if (do_release) begin
      held_ext = held_ext - 1'b1;
    end
  end
endmodule

### tb/sv/timed_event_release_queue_tb.sv
// Self-checking testbench of the timed event release queue with a predictor and random traffic.
module timed_event_release_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import teq_pkg::*;

  localparam int DEPTH     = 64;
  localparam int TAG_BITS  = 32;
  localparam int TIME_BITS = 48;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int HOLD_CYCLES  = 3000;

  typedef struct packed {
    logic                 operation;
    logic [TAG_BITS-1:0]  event_tag;
    logic [TIME_BITS-1:0] due_time;
    logic                 prefetch_flag;
    logic [TIME_BITS-1:0] now_time;
  } queue_op_t;

  typedef struct packed {
    logic                  released;
    logic [TAG_BITS-1:0]   out_tag;
    logic [TIME_BITS-1:0]  out_due_time;
    logic                  out_prefetch;
    logic                  accepted;
    logic [COUNT_BITS-1:0] pending_count;
  } release_t;

  logic clk;
  logic rst;

  teq_in_if  #(.TAG_BITS(TAG_BITS), .TIME_BITS(TIME_BITS)) in_ch();
  teq_out_if #(.TAG_BITS(TAG_BITS), .TIME_BITS(TIME_BITS)) out_ch();
  teq_cfg_if cfg_ch();

  timed_event_release_queue #(
    .DEPTH(DEPTH), .TAG_BITS(TAG_BITS), .TIME_BITS(TIME_BITS)
  ) u_top (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
  );

  // Predictor state: a shadow of the slot memory.
  logic [TIME_BITS-1:0] pm_due    [DEPTH];
  logic [TAG_BITS-1:0]  pm_tag    [DEPTH];
  logic                 pm_pf     [DEPTH];
  logic [31:0]          pm_stamp  [DEPTH];
  logic                 pm_valid  [DEPTH];
  int unsigned          pm_held;
  logic [31:0]          pm_next_stamp;
  logic                 pm_ooo;

  queue_op_t pending_ops[$];
  release_t  expected_releases[$];
  int        snd_idle;
  int        rcv_idle;
  bit        holding;
  bit        in_taken;
  int        mismatches;
  logic [TIME_BITS-1:0] clock_base;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic release_t predict_release(queue_op_t op);
    release_t r;
    bit found;
    int best;
    bit better;
    r = '0;
    found = 0;
    best = 0;
    if (op.operation == OP_SCHEDULE) begin
      if (pm_held < DEPTH) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!pm_valid[i]) begin
            pm_valid[i] = 1'b1;
            pm_tag[i]   = op.event_tag;
            pm_due[i]   = op.due_time;
            pm_pf[i]    = op.prefetch_flag;
            pm_stamp[i] = pm_next_stamp;
            pm_next_stamp = pm_next_stamp + 32'd1;
            pm_held++;
            r.accepted = 1'b1;
            break;
          end
        end
      end
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (pm_valid[i]) begin
          if (!found) begin
            better = 1;
          end else if (pm_ooo) begin
            better = pm_due[i] < pm_due[best] ||
                     (pm_due[i] == pm_due[best] &&
                      (pm_next_stamp - pm_stamp[i]) > (pm_next_stamp - pm_stamp[best]));
          end else begin
            better = (pm_next_stamp - pm_stamp[i]) > (pm_next_stamp - pm_stamp[best]);
          end
          if (better) begin
            best = i;
            found = 1;
          end
        end
      end
      if (found && pm_due[best] <= op.now_time) begin
        r.released     = 1'b1;
        r.out_tag      = pm_tag[best];
        r.out_due_time = pm_due[best];
        r.out_prefetch = pm_pf[best];
        pm_valid[best] = 1'b0;
        if (pm_held > 0) pm_held--;
      end
    end
    r.pending_count = pm_held[COUNT_BITS-1:0];
    return r;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic queue_op_t make_schedule(logic [TAG_BITS-1:0] tag,
                                              logic [TIME_BITS-1:0] due, logic pf);
    queue_op_t op;
    op = '0;
    op.operation     = OP_SCHEDULE;
    op.event_tag     = tag;
    op.due_time      = due;
    op.prefetch_flag = pf;
    op.now_time      = rand_time();
    return op;
  endfunction

  function automatic queue_op_t make_pick(logic [TIME_BITS-1:0] now);
    queue_op_t op;
    op = '0;
    op.operation     = OP_PICK;
    op.event_tag     = $urandom;
    op.due_time      = rand_time();
    op.prefetch_flag = rand_bit();
    op.now_time      = now;
    return op;
  endfunction

  task automatic queue_item(queue_op_t op);
    pending_ops = {pending_ops, op};
  endtask

  // Input side: an item is taken at a rising edge with valid and ready high.
  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (!rst && in_taken) begin
      expected_releases = {expected_releases,
        predict_release({in_ch.operation, in_ch.event_tag, in_ch.due_time,
                         in_ch.prefetch_flag, in_ch.now_time})};
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_ch.valid || in_taken)) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= snd_idle) begin
        {in_ch.operation, in_ch.event_tag, in_ch.due_time, in_ch.prefetch_flag,
         in_ch.now_time} <= pending_ops.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || holding) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    release_t got;
    release_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.released, out_ch.out_tag, out_ch.out_due_time, out_ch.out_prefetch,
             out_ch.accepted, out_ch.pending_count};
      if (expected_releases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = expected_releases.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_ops.size() > 0 || in_ch.valid || expected_releases.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic mode);
    @(negedge clk);
    cfg_ch.data  <= mode;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    pm_ooo = mode;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One well-formed burst around a moving time base, so picks often find due events.
  task automatic add_mixed_run(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 55) begin
        queue_item(make_schedule($urandom, clock_base + TIME_BITS'($urandom_range(40)),
                                 rand_bit()));
      end else begin
        queue_item(make_pick(clock_base));
      end
      clock_base = clock_base + TIME_BITS'($urandom_range(8));
    end
  endtask

  task automatic add_random_phase(int budget);
    int used;
    int sel;
    used = 0;
    while (used < budget) begin
      sel = $urandom_range(9);
      clock_base = rand_time() >> 1;
      if (sel == 0) begin
        // Overfill so that the last schedules are dropped, then drain.
        for (int k = 0; k < DEPTH + 4; k++)
          queue_item(make_schedule($urandom, clock_base + TIME_BITS'($urandom_range(30)),
                                   rand_bit()));
        for (int k = 0; k < DEPTH + 2; k++)
          queue_item(make_pick(clock_base + TIME_BITS'(2 * k)));
        used += 2 * DEPTH + 6;
      end else if (sel == 1) begin
        for (int k = 0; k < 8; k++) begin
          if ($urandom_range(1))
            queue_item(make_schedule($urandom, rand_time(), rand_bit()));
          else
            queue_item(make_pick(rand_time()));
        end
        used += 8;
      end else begin
        add_mixed_run(12);
        used += 12;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_SCHEDULE;
    in_ch.event_tag = '0;
    in_ch.due_time = '0;
    in_ch.prefetch_flag = 1'b0;
    in_ch.now_time = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    holding = 0;
    in_taken = 0;
    mismatches = 0;
    snd_idle = 29;
    rcv_idle = 79;
    for (int i = 0; i < DEPTH; i++) pm_valid[i] = 1'b0;
    pm_held = 0;
    pm_next_stamp = '0;
    pm_ooo = 1'b0;
    clock_base = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Order mode: empty pick, extremes, and an oldest event that blocks a due one.
    write_mode(1'b0);
    queue_item(make_pick('0));
    queue_item(make_schedule('1, '1, 1'b1));
    queue_item(make_schedule('0, '0, 1'b0));
    queue_item(make_schedule(32'h5a5a_a5a5, 48'd5, 1'b1));
    queue_item(make_pick('0));
    queue_item(make_pick('1));
    queue_item(make_pick('1));
    queue_item(make_pick('1));
    queue_item(make_pick('1));
    wait_idle();

    // Out-of-order mode: earliest due wins, ties go to the oldest.
    write_mode(1'b1);
    queue_item(make_schedule(32'd1, 48'd100, 1'b0));
    queue_item(make_schedule(32'd2, 48'd50, 1'b1));
    queue_item(make_schedule(32'd3, 48'd50, 1'b0));
    queue_item(make_schedule(32'd4, 48'd200, 1'b1));
    queue_item(make_pick(48'd49));
    queue_item(make_pick(48'd50));
    queue_item(make_pick(48'd50));
    queue_item(make_pick('1));
    queue_item(make_schedule(32'd5, 48'd10, 1'b0));
    queue_item(make_schedule(32'd6, 48'd5, 1'b1));
    wait_idle();

    // Mode change with events held: the next pick selects the oldest, which is not yet due.
    write_mode(1'b0);
    queue_item(make_pick(48'd10));
    queue_item(make_pick('1));
    queue_item(make_pick('1));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        snd_idle = 29;
        rcv_idle = 79;
      end else if (p < 4) begin
        snd_idle = 79;
        rcv_idle = 29;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      write_mode(p[0]);
      add_random_phase(215);
      if (p == 4) begin
        // Long receiver stall while the sender keeps offering.
        fork
          begin
            holding = 1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 0;
          end
        join_none
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_releases.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("simulation failed");
    $finish;
  end
endmodule

### timed_event_release_queue.f
hdl/teq_pkg.sv
hdl/teq_if.sv
hdl/teq_slot_ram.sv
hdl/timed_event_release_queue.sv
tb/sv/timed_event_release_queue_tb.sv
